/* rtl/rfp_pkg.sv */
package rfp_pkg;

    // fixed frame overhead: head1, head2, cmd, len, sum, tail
    localparam int FRAME_OVH = 6;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE   = 2'd2;

    // payload offset of the first payload byte inside a frame
    localparam int PAY_OFS = 4;

    // scan sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_B0,
        S_B1,
        S_B2,
        S_B3,
        S_TAIL,
        S_SUM,
        S_CMP,
        S_EMIT
    } t_state;

    // one result beat
    typedef struct packed {
        logic [7:0] frame_cmd;
        logic [5:0] pay_len;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } t_res;

    // sequencer to output stage
    typedef struct packed {
        logic load;
        t_res res;
    } t_push;

endpackage

/* rtl/rfp_in_if.sv */
interface rfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/rfp_out_if.sv */
interface rfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_cmd;
    logic [5:0] pay_len;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last_of_frame;

    modport source (
        output valid, output frame_cmd, output pay_len, output byte_index,
        output payload_byte, output last_of_frame, input ready
    );
    modport sink (
        input valid, input frame_cmd, input pay_len, input byte_index,
        input payload_byte, input last_of_frame, output ready
    );
endinterface

/* rtl/rfp_ram.sv */
module rfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/rfp_seq.sv */
module rfp_seq #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_in_byte,
    output logic                           o_ram_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                     o_ram_wdata,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_ram_raddr,
    input  logic [7:0]                     i_ram_rdata,
    output rfp_pkg::t_push                 o_push,
    input  logic                           i_out_free
);
    import rfp_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int EW = (CW > 9) ? CW : 9;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [EW-1:0] DEPTH_E = EW'(BUFFER_DEPTH);
    localparam logic [EW-1:0] OVH_E   = EW'(FRAME_OVH);

    // circular index add, offset never above the depth
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW:0] ofs);
        logic [AW:0] s;
        s = {1'b0, base} + ofs;
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_cmd, n_cmd;
    logic [7:0]    r_len, n_len;
    logic [AW-1:0] r_off, n_off;
    logic [7:0]    r_head_first, r_head_second, r_tail_byte;

    logic          drop;
    logic [AW:0]   drop_n;
    logic [AW:0]   rd_off;
    logic [EW-1:0] flen_new;
    logic [EW-1:0] len_ext;
    logic          at_last;
    logic [AW-1:0] idx_w;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first  <= '0;
            r_head_second <= '0;
            r_tail_byte   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HEAD_FIRST:  r_head_first  <= i_cfg_data;
                REG_HEAD_SECOND: r_head_second <= i_cfg_data;
                REG_TAIL_BYTE:   r_tail_byte   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state and buffer pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // scan datapath registers
    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_cmd <= n_cmd;
        r_len <= n_len;
        r_off <= n_off;
    end

    assign flen_new = EW'(i_ram_rdata) + OVH_E;
    assign len_ext  = EW'(r_len);
    assign at_last  = (EW'(r_off) == len_ext + EW'(PAY_OFS - 1));
    assign idx_w    = r_off - AW'(PAY_OFS);

    // next state, buffer access and result push
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_sum       = r_sum;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_off       = r_off;
        drop        = 1'b0;
        drop_n      = (AW + 1)'(1);
        rd_off      = '0;
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = wrap_add(r_head, (AW + 1)'(r_count));
        o_ram_wdata = i_in_byte;

        o_push.load               = 1'b0;
        o_push.res.frame_cmd      = r_cmd;
        o_push.res.pay_len        = r_len[5:0];
        o_push.res.byte_index     = 6'(idx_w);
        o_push.res.payload_byte   = i_ram_rdata;
        o_push.res.last_of_frame  = at_last;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ram_we = 1'b1;
                    // full buffer: oldest byte is overwritten
                    if (r_count == DEPTH_C) begin
                        o_ram_waddr = r_head;
                        n_head      = wrap_add(r_head, (AW + 1)'(1));
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_count < CW'(FRAME_OVH)) begin
                    n_state = S_IDLE;
                end else begin
                    rd_off  = '0;
                    n_state = S_B0;
                end
            end
            S_B0: begin
                if (i_ram_rdata != r_head_first) begin
                    drop = 1'b1;
                end else begin
                    n_sum   = i_ram_rdata;
                    rd_off  = (AW + 1)'(1);
                    n_state = S_B1;
                end
            end
            S_B1: begin
                if (i_ram_rdata != r_head_second) begin
                    drop = 1'b1;
                end else begin
                    n_sum   = r_sum + i_ram_rdata;
                    rd_off  = (AW + 1)'(2);
                    n_state = S_B2;
                end
            end
            S_B2: begin
                n_cmd   = i_ram_rdata;
                n_sum   = r_sum + i_ram_rdata;
                rd_off  = (AW + 1)'(3);
                n_state = S_B3;
            end
            S_B3: begin
                // length byte: zero or too long is a resync
                if (i_ram_rdata == 8'd0 || flen_new > DEPTH_E) begin
                    drop = 1'b1;
                end else if (EW'(r_count) < flen_new) begin
                    n_state = S_IDLE;
                end else begin
                    n_len   = i_ram_rdata;
                    n_sum   = r_sum + i_ram_rdata;
                    rd_off  = (AW + 1)'(flen_new - EW'(1));
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_ram_rdata != r_tail_byte) begin
                    drop = 1'b1;
                end else begin
                    n_off   = AW'(PAY_OFS);
                    rd_off  = (AW + 1)'(PAY_OFS);
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // one payload byte into the running sum per cycle
                n_sum = r_sum + i_ram_rdata;
                if (at_last) begin
                    rd_off  = (AW + 1)'(len_ext + EW'(PAY_OFS));
                    n_state = S_CMP;
                end else begin
                    n_off  = r_off + AW'(1);
                    rd_off = {1'b0, r_off} + (AW + 1)'(1);
                end
            end
            S_CMP: begin
                if (i_ram_rdata != r_sum) begin
                    drop = 1'b1;
                end else begin
                    n_off   = AW'(PAY_OFS);
                    rd_off  = (AW + 1)'(PAY_OFS);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold the read address while the output stage is busy
                rd_off = {1'b0, r_off};
                if (i_out_free) begin
                    o_push.load = 1'b1;
                    if (at_last) begin
                        drop   = 1'b1;
                        drop_n = (AW + 1)'(len_ext + OVH_E);
                    end else begin
                        n_off  = r_off + AW'(1);
                        rd_off = {1'b0, r_off} + (AW + 1)'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // drop bytes from the buffer front and rescan
        if (drop) begin
            n_head  = wrap_add(r_head, drop_n);
            n_count = r_count - CW'(drop_n);
            n_state = S_CHK;
        end
    end

    assign o_ram_raddr = wrap_add(r_head, rd_off);
endmodule

/* rtl/rfp_out.sv */
module rfp_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfp_pkg::t_push   i_push,
    output logic             o_free,
    rfp_out_if.source        o_res
);
    import rfp_pkg::*;

    logic r_valid;
    t_res r_res;

    // output register, refilled in the cycle it is taken
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.load) begin
            r_res <= i_push.res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.frame_cmd     = r_res.frame_cmd;
    assign o_res.pay_len       = r_res.pay_len;
    assign o_res.byte_index    = r_res.byte_index;
    assign o_res.payload_byte  = r_res.payload_byte;
    assign o_res.last_of_frame = r_res.last_of_frame;
endmodule

/* rtl/resync_frame_parser_top.sv */
// a byte that completes no frame is written to the buffer, then each buffered byte
// position tried: S_CHK, S_B0, then S_B1 to S_TAIL while header and length pass
// a full frame check runs S_SUM and S_CMP (one buffer read per cycle through one adder),
// then len beats of output, one per cycle while the sink is ready
// throughput: next byte accepted only after the scan of the previous one ends
// reset: synchronous active low; buffer empty, config zero, data regs and ram not reset
module resync_frame_parser_top #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    rfp_in_if.sink                        i_rx,
    rfp_out_if.source                     o_res
);
    import rfp_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          in_ready;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    t_push         push;
    logic          out_free;

    assign i_rx.ready = in_ready;

    // byte buffer
    rfp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // scan sequencer
    rfp_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (in_ready),
        .i_in_byte   (i_rx.rx_byte),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_push      (push),
        .i_out_free  (out_free)
    );

    // result output register
    rfp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (out_free),
        .o_res   (o_res)
    );
endmodule

/* test/testbench.sv */
module testbench;
    import rfp_pkg::*;

    localparam int RX_DEPTH      = 64;
    localparam int MAX_PAYLOAD   = RX_DEPTH - FRAME_OVH;
    localparam int DRAIN_CYCLES  = 5000;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASE_BYTES   = 22;

    // receive-side frame predictor and expected beat store
    class frame_scoreboard;
        logic [7:0] head1;
        logic [7:0] head2;
        logic [7:0] tail;
        logic [7:0] rx_buf[$];
        t_res       beat_q[$];
        int         errors;

        function new();
            head1  = 8'h00;
            head2  = 8'h00;
            tail   = 8'h00;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                REG_HEAD_FIRST:  head1 = val;
                REG_HEAD_SECOND: head2 = val;
                REG_TAIL_BYTE:   tail  = val;
                default: ;
            endcase
        endfunction

        // append one accepted byte and rescan the buffer for frames
        function void note_byte(logic [7:0] b);
            int         plen;
            int         flen;
            int         i;
            logic [7:0] sum;
            bit         scanning;
            bit         drop_one;
            t_res       r;
            if (rx_buf.size() >= RX_DEPTH) void'(rx_buf.pop_front());
            rx_buf.push_back(b);
            scanning = 1'b1;
            while (scanning && rx_buf.size() >= FRAME_OVH) begin
                drop_one = 1'b1;
                if (rx_buf[0] == head1 && rx_buf[1] == head2) begin
                    plen = rx_buf[3];
                    flen = plen + FRAME_OVH;
                    if (plen != 0 && flen <= RX_DEPTH) begin
                        if (rx_buf.size() < flen) begin
                            // incomplete frame: wait for more bytes
                            scanning = 1'b0;
                            drop_one = 1'b0;
                        end else if (rx_buf[flen-1] == tail) begin
                            sum = 8'h00;
                            for (i = 0; i < flen - 2; i++) sum = sum + rx_buf[i];
                            if (sum == rx_buf[flen-2]) begin
                                for (i = 0; i < plen; i++) begin
                                    r.frame_cmd     = rx_buf[2];
                                    r.pay_len       = plen[5:0];
                                    r.byte_index    = i[5:0];
                                    r.payload_byte  = rx_buf[PAY_OFS+i];
                                    r.last_of_frame = (i + 1 == plen);
                                    beat_q.push_back(r);
                                end
                                repeat (flen) void'(rx_buf.pop_front());
                                drop_one = 1'b0;
                            end
                        end
                    end
                end
                if (drop_one) void'(rx_buf.pop_front());
            end
        endfunction

        // compare one output beat against the oldest expected one
        function void check_beat(t_res got);
            t_res want;
            if (beat_q.size() == 0) begin
                $error("unexpected beat: frame_cmd %0h byte_index %0d",
                       got.frame_cmd, got.byte_index);
                errors++;
                return;
            end
            want = beat_q.pop_front();
            if (got.frame_cmd !== want.frame_cmd) begin
                $error("frame_cmd: expected %0h, got %0h", want.frame_cmd, got.frame_cmd);
                errors++;
            end
            if (got.pay_len !== want.pay_len) begin
                $error("pay_len: expected %0d, got %0d", want.pay_len, got.pay_len);
                errors++;
            end
            if (got.byte_index !== want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
                errors++;
            end
            if (got.payload_byte !== want.payload_byte) begin
                $error("payload_byte: expected %0h, got %0h",
                       want.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %0b, got %0b",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [7:0]           cfg_data = 8'h00;
    bit                   quiet = 1'b0;
    int                   sent_count = 0;
    int                   cycles = 0;
    logic [7:0]           tx_q[$];
    frame_scoreboard      sb = new();
    t_res                 got_beat;

    rfp_in_if  rx_if ();
    rfp_out_if res_if ();

    resync_frame_parser_top #(
        .BUFFER_DEPTH(RX_DEPTH)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_rx      (rx_if),
        .o_res     (res_if)
    );

    // clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // output beat monitor
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            got_beat.frame_cmd     = res_if.frame_cmd;
            got_beat.pay_len       = res_if.pay_len;
            got_beat.byte_index    = res_if.byte_index;
            got_beat.payload_byte  = res_if.payload_byte;
            got_beat.last_of_frame = res_if.last_of_frame;
            sb.check_beat(got_beat);
        end
    end

    // output back-pressure in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // queue one frame with the current sync and tail bytes; fill < 0 means random payload
    function automatic void add_frame(logic [7:0] cmd, int len, int fill);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        tx_q.push_back(sb.head1);
        tx_q.push_back(sb.head2);
        tx_q.push_back(cmd);
        tx_q.push_back(len[7:0]);
        sum = sb.head1 + sb.head2 + cmd + len[7:0];
        for (i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            tx_q.push_back(b);
            sum = sum + b;
        end
        tx_q.push_back(sum);
        tx_q.push_back(sb.tail);
    endfunction

    // one input beat, with an optional idle burst ahead of it
    task automatic send_byte(logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        sb.note_byte(b);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_all();
        while (tx_q.size() > 0) send_byte(tx_q.pop_front());
    endtask

    // wait until every expected beat is out and the scan has settled
    task automatic settle();
        while (sb.beat_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_config(logic [7:0] h1, logic [7:0] h2, logic [7:0] t);
        rx_if.valid <= 1'b0;
        settle();
        write_reg(REG_HEAD_FIRST, h1);
        write_reg(REG_HEAD_SECOND, h2);
        write_reg(REG_TAIL_BYTE, t);
        cfg_we <= 1'b0;
    endtask

    // mix of good frames, corrupted frames and line noise
    task automatic random_traffic(int nbytes);
        int start_cnt;
        int pick;
        int len;
        int pos;
        int n;
        start_cnt = sent_count;
        while (sent_count - start_cnt < nbytes) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            if (pick < 65) begin
                add_frame(8'($urandom_range(0, 255)), len, -1);
            end else if (pick < 85) begin
                // corrupt one byte anywhere in the frame
                add_frame(8'($urandom_range(0, 255)), len, -1);
                pos = $urandom_range(0, len + FRAME_OVH - 1);
                tx_q[pos] = tx_q[pos] ^ 8'($urandom_range(1, 255));
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0:       tx_q.push_back(sb.head1);
                        1:       tx_q.push_back(sb.head2);
                        2:       tx_q.push_back(sb.tail);
                        default: tx_q.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            send_all();
        end
    endtask

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames and error cases
        set_config(8'hAA, 8'h55, 8'h0D);
        add_frame(8'hFF, 1, 8'hFF);
        add_frame(8'h00, 1, 8'h00);
        // zero length header, then a good frame
        tx_q.push_back(8'hAA); tx_q.push_back(8'h55);
        tx_q.push_back(8'h12); tx_q.push_back(8'h00);
        add_frame(8'h34, 2, -1);
        // oversized length header
        tx_q.push_back(8'hAA); tx_q.push_back(8'h55);
        tx_q.push_back(8'h12); tx_q.push_back(8'(MAX_PAYLOAD + 1));
        add_frame(8'h35, 1, -1);
        // bad tail
        add_frame(8'h56, 1, -1);
        tx_q[tx_q.size()-1] = ~tx_q[tx_q.size()-1];
        // bad sum
        add_frame(8'h57, 1, -1);
        tx_q[tx_q.size()-2] = tx_q[tx_q.size()-2] ^ 8'h01;
        // false start byte ahead of a frame
        tx_q.push_back(8'hAA);
        add_frame(8'h58, 3, -1);
        // long pending header hides two frames that its failed tail uncovers
        tx_q.push_back(8'hAA); tx_q.push_back(8'h55);
        tx_q.push_back(8'hC1); tx_q.push_back(8'h10);
        add_frame(8'h61, 1, -1);
        add_frame(8'h62, 1, -1);
        tx_q.push_back(8'h01); tx_q.push_back(8'h02);
        tx_q.push_back(8'h03); tx_q.push_back(8'h04);
        send_all();

        // all-zero sync and tail
        set_config(8'h00, 8'h00, 8'h00);
        random_traffic(PHASE_BYTES);

        // all-ones sync and tail, longest frame
        set_config(8'hFF, 8'hFF, 8'hFF);
        add_frame(8'h00, MAX_PAYLOAD, -1);
        send_all();
        random_traffic(PHASE_BYTES);

        // random sync and tail
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        random_traffic(PHASE_BYTES);

        // final stretch without idling on either side
        set_config(8'hAA, 8'h55, 8'h0D);
        quiet = 1'b1;
        add_frame(8'hFF, MAX_PAYLOAD, 8'hFF);
        send_all();
        random_traffic(PHASE_BYTES);

        rx_if.valid <= 1'b0;
        settle();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
